### design/csvfp_pkg.sv
// csvfp_pkg: shared types and byte codes for the CSV field parser.
// Used by csvfp_step and csv_field_parser_top; no dependencies.
package csvfp_pkg;

   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_END   = 8'h00;

   typedef enum logic [2:0] {
      ST_LINE_START  = 3'd0,
      ST_FIELD_START = 3'd1,
      ST_PLAIN       = 3'd2,
      ST_QUOTED      = 3'd3,
      ST_AFTER_QUOTE = 3'd4
   } parse_state_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_input;
   } csvfp_req_type;

   typedef struct packed {
      logic [7:0] char_out;
      logic       char_valid;
      logic       field_end;
      logic       record_end;
      logic       stream_end;
   } csvfp_rsp_type;

endpackage

### design/csvfp_step.sv
// csvfp_step: one parser step - next state and optional result word for one byte.
// Purely combinational; depends on csvfp_pkg.
module csvfp_step
   import csvfp_pkg::*;
(
   input  parse_state_type state,
   input  csvfp_req_type   item,
   output parse_state_type next_state,
   output logic            has_result,
   output csvfp_rsp_type   result
);

   logic [7:0]    ch;
   csvfp_rsp_type content_word;
   csvfp_rsp_type field_word;
   csvfp_rsp_type record_word;
   csvfp_rsp_type stream_word;

   always_comb begin
      ch = item.end_of_input ? CH_END : item.in_byte;

      content_word            = '0;
      content_word.char_out   = ch;
      content_word.char_valid = 1'b1;

      field_word           = '0;
      field_word.field_end = 1'b1;

      record_word            = field_word;
      record_word.record_end = 1'b1;

      stream_word            = '0;
      stream_word.stream_end = 1'b1;
   end

   always_comb begin
      next_state = state;
      has_result = 1'b0;
      result     = '0;
      if (ch != CH_CR) begin
         unique case (state)
            ST_PLAIN, ST_AFTER_QUOTE: begin
               priority if (state == ST_AFTER_QUOTE && ch == CH_QUOTE) begin
                  // doubled quote: one literal quote
                  has_result = 1'b1;
                  result     = content_word;
                  next_state = ST_QUOTED;
               end else if (ch == CH_COMMA) begin
                  has_result = 1'b1;
                  result     = field_word;
                  next_state = ST_FIELD_START;
               end else if (ch == CH_LF || ch == CH_END) begin
                  has_result = 1'b1;
                  result     = record_word;
                  next_state = ST_LINE_START;
               end else begin
                  has_result = 1'b1;
                  result     = content_word;
                  next_state = ST_PLAIN;
               end
            end
            ST_QUOTED: begin
               priority if (ch == CH_QUOTE) begin
                  next_state = ST_AFTER_QUOTE;
               end else if (ch == CH_END) begin
                  has_result = 1'b1;
                  result     = record_word;
                  next_state = ST_LINE_START;
               end else begin
                  has_result = 1'b1;
                  result     = content_word;
               end
            end
            default: begin
               // line start, field start, and unused codes taken as line start
               priority if (ch == CH_END && state != ST_FIELD_START) begin
                  has_result = 1'b1;
                  result     = stream_word;
                  next_state = ST_LINE_START;
               end else if (ch == CH_QUOTE) begin
                  next_state = ST_QUOTED;
               end else if (ch == CH_COMMA) begin
                  has_result = 1'b1;
                  result     = field_word;
                  next_state = ST_FIELD_START;
               end else if (ch == CH_LF || ch == CH_END) begin
                  has_result = 1'b1;
                  result     = record_word;
                  next_state = ST_LINE_START;
               end else begin
                  has_result = 1'b1;
                  result     = content_word;
                  next_state = ST_PLAIN;
               end
            end
         endcase
      end
   end

endmodule

### design/csv_field_parser_top.sv
// csv_field_parser_top: byte-serial CSV field and record splitter, top level.
// Depends on csvfp_pkg and csvfp_step.

// One raw byte per request word, one result word per byte at most. A request
// word is first captured in an input register; from there the parser step
// (a five-state machine: line start, field start, plain field, quoted field,
// after closing quote) decides the next state and the result, which is
// written to the output register. Throughput is one byte per cycle unless a
// byte with a result waits for a full output register that is not being
// drained. The output register lets a new byte be taken while a finished
// result waits for rsp_ready; bytes giving no result (carriage returns,
// quotes that open or close a quoted field) pass through without holding
// the pipe. A result word carries either a content byte (char_valid), a
// field end (field_end, with record_end on the last field of a line), or
// stream_end for end of input at line start. A zero byte or end_of_input
// counts as end of input; input after stream end starts a fresh stream.
module csv_field_parser_top
   import csvfp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  csvfp_req_type req_data,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output csvfp_rsp_type rsp_data
);

   // input register
   logic            in_valid_ff;
   logic            in_valid_in;
   csvfp_req_type   in_data_ff;

   // parser state
   parse_state_type state_ff;
   parse_state_type state_in;

   // output register
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   csvfp_rsp_type   rsp_data_ff;

   logic            has_result;
   csvfp_rsp_type   step_result;
   parse_state_type step_state;
   logic            out_free;
   logic            advance;
   logic            load_rsp;

   csvfp_step u_step (
      .state      (state_ff),
      .item       (in_data_ff),
      .next_state (step_state),
      .has_result (has_result),
      .result     (step_result)
   );

   // the held byte moves on if it makes no result or the output slot frees
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && (out_free || !has_result);
   assign load_rsp  = advance && has_result;
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = req_ready ? req_valid : in_valid_ff;
      state_in    = advance ? step_state : state_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         state_ff     <= ST_LINE_START;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (load_rsp) begin
         rsp_data_ff <= step_result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a result word is exactly one of: content byte, field end, stream end
   a_rsp_kind_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $onehot({rsp_data_ff.char_valid, rsp_data_ff.field_end,
                                rsp_data_ff.stream_end}))
      else $error("result word kind not one-hot");

   a_record_has_field: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.record_end |-> rsp_data_ff.field_end)
      else $error("record end without field end");

   a_marker_no_char: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.char_valid |-> rsp_data_ff.char_out == CH_END)
      else $error("marker word carries a byte");

   a_record_to_line_start: assert property (@(posedge clock) disable iff (reset)
      load_rsp && (step_result.record_end || step_result.stream_end)
      |=> state_ff == ST_LINE_START)
      else $error("record or stream end not followed by line start");

   a_stall_holds_byte: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_data_ff)
                                   && $stable(state_ff))
      else $error("held byte lost while output stalled");

endmodule
